// ----- rtl/assert_macros.svh -----
// Assertion macros for the port checker of the toggle burst generator.
// Depends on nothing; each macro places one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mctbg_pkg.sv -----
// Shared types, codes and helpers of the multi-channel toggle burst generator.
// Used by the channel cell, the top level and the port checker.
`default_nettype none

package mctbg_pkg;

  // Table size and per-tick limits.
  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned MAX_RESULTS  = 8;
  localparam int unsigned CNT_W        = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int unsigned PIN_W  = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TGL_W  = 16;
  localparam int unsigned SLOT_W = 3;

  // Packed beat widths.
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 16;

  // Input selector codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POST = 1'b1;

  // Result kind codes.
  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_TOGGLE = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              advance;
    logic              start;
    logic              post;
    logic              claimed;
    logic              room;
    logic [TIME_W-1:0] now;
    logic [PIN_W-1:0]  pin;
    logic [TIME_W-1:0] half;
    logic [TGL_W-1:0]  count;
    logic [TIME_W-1:0] start_time;
  } cell_ctl_t;

  // What the cell holding the token reports; zero from all other cells.
  typedef struct packed {
    logic              hit;
    logic              claim;
    logic [SLOT_W-1:0] slot;
    logic [PIN_W-1:0]  pin;
    logic              fin;
  } cell_out_t;

  // One result beat.
  typedef struct packed {
    logic              kind;
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic [PIN_W-1:0]  pin;
    logic              fin;
    logic              last;
  } result_t;

  // Wrap-safe test that time t has been reached at time now.
  function automatic logic reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] d;
    d = now - t;
    return !d[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/multi_channel_toggle_burst_generator_unit.sv -----
// Top level of the multi-channel toggle burst generator: sequencer, result
// buffers and the row of channel cells. Depends on mctbg_pkg and mctbg_cell.
`default_nettype none

// Each input beat is either a millisecond tick or a post of a toggle task.
// Both are handled by walking a token along the row of CHANNELS cells, one
// cell per cycle; an item passes through the accepting cycle, the walk and a
// flush state that hands over the final result, and the walk and the flush
// can wait while the output side holds tready low. A post lands in the
// lowest free cell the token meets and gives one reply beat; a tick fires
// every due channel in slot order, at most MAX_RESULTS toggle beats, the
// final one flagged by tlast. A quiet tick gives no beat at all. The input
// is taken again once the final result has moved into the output register,
// even if it still waits there.

module multi_channel_toggle_burst_generator_unit
  import mctbg_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  // Input beat.
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata, lowest bit up: pin[7:0], half_period[39:8],
  // toggle_count[55:40], start_delay[87:56].
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd.
  input  wire                   s_axis_tuser,
  // Result beat.
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // tdata, lowest bit up: accepted[0], slot[3:1], pin_out[11:4],
  // finished[12], zero[15:13].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: kind.
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  state_t            state;
  state_t            state_next;

  logic [TIME_W-1:0] ms_clock;
  logic              c_post;
  logic [PIN_W-1:0]  c_pin;
  logic [TIME_W-1:0] c_half;
  logic [TGL_W-1:0]  c_count;
  logic [TIME_W-1:0] c_start;
  logic [CNT_W-1:0]  n_events;

  result_t           obuf;
  logic              obuf_v;
  result_t           pend;
  logic              pend_v;

  logic              accept;
  logic              scanning;
  logic              push_ok;
  logic              advance;
  logic              scan_done;
  logic              flush_go;

  logic [PIN_W-1:0]  in_pin;
  logic [TIME_W-1:0] in_half;
  logic [TGL_W-1:0]  in_count;
  logic [TIME_W-1:0] in_delay;

  cell_ctl_t         ctl;
  cell_out_t         rpt [CHANNELS];
  cell_out_t         bus;
  logic [CHANNELS-1:0] tok;

  // Unpack the input beat.
  assign in_pin   = s_axis_tdata[7:0];
  assign in_half  = s_axis_tdata[39:8];
  assign in_count = s_axis_tdata[55:40];
  assign in_delay = s_axis_tdata[87:56];

  // Gather the report of the cell holding the token.
  always_comb begin
    bus = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      bus = bus | rpt[i];
    end
  end

  // Sequencer: next state and handshake decisions.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    scanning      = (state == ST_SCAN);
    push_ok       = !pend_v || !obuf_v || m_axis_tready;
    advance       = scanning && (!bus.hit || push_ok);
    scan_done     = advance && tok[CHANNELS-1];
    flush_go      = (state == ST_FLUSH) && pend_v && (!obuf_v || m_axis_tready);

    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || flush_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Millisecond clock and the latched command.
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_clock <= '0;
    end else if (accept && (s_axis_tuser == CMD_TICK)) begin
      ms_clock <= ms_clock + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_post  <= (s_axis_tuser == CMD_POST);
      c_pin   <= in_pin;
      c_half  <= (in_half == '0) ? TIME_W'(1) : in_half;
      c_count <= in_count;
      c_start <= ms_clock + in_delay;
    end
  end

  // Broadcast controls to the cells.
  always_comb begin
    ctl            = '0;
    ctl.advance    = advance;
    ctl.start      = accept;
    ctl.post       = c_post;
    ctl.claimed    = pend.accepted;
    ctl.room       = (n_events < CNT_W'(MAX_RESULTS));
    ctl.now        = ms_clock;
    ctl.pin        = c_pin;
    ctl.half       = c_half;
    ctl.count      = c_count;
    ctl.start_time = c_start;
  end

  // Row of channel cells; the token passes from each cell to the next.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    logic tok_in;
    if (g == 0) begin : g_head
      assign tok_in = 1'b0;
    end else begin : g_link
      assign tok_in = tok[g-1];
    end
    mctbg_cell #(
      .IDX (g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .tok_in (tok_in),
      .tok    (tok[g]),
      .rpt    (rpt[g])
    );
  end

  // Pending result: the newest event or the post reply, held back until
  // it is known whether it is the last one of the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v        <= 1'b0;
      pend.accepted <= 1'b0;
      n_events      <= '0;
    end else if (accept) begin
      pend_v        <= (s_axis_tuser == CMD_POST);
      pend.accepted <= 1'b0;
      n_events      <= '0;
    end else if (advance && bus.hit) begin
      pend_v        <= 1'b1;
      pend.accepted <= 1'b0;
      n_events      <= n_events + CNT_W'(1);
    end else if (advance && bus.claim) begin
      pend.accepted <= 1'b1;
    end else if (flush_go) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend.kind <= KIND_REPLY;
      pend.slot <= '0;
      pend.pin  <= '0;
      pend.fin  <= 1'b0;
      pend.last <= 1'b0;
    end else if (advance && bus.hit) begin
      pend.kind <= KIND_TOGGLE;
      pend.slot <= bus.slot;
      pend.pin  <= bus.pin;
      pend.fin  <= bus.fin;
      pend.last <= 1'b0;
    end else if (advance && bus.claim) begin
      pend.slot <= bus.slot;
    end
  end

  // Output register: takes the pending beat when a newer event displaces it,
  // or at the end of the item with tlast set.
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_v <= 1'b0;
    end else if ((advance && bus.hit && pend_v) || flush_go) begin
      obuf_v <= 1'b1;
    end else if (m_axis_tready) begin
      obuf_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && bus.hit && pend_v) begin
      obuf <= pend;
    end else if (flush_go) begin
      obuf <= '{kind: pend.kind, accepted: pend.accepted, slot: pend.slot,
                pin: pend.pin, fin: pend.fin, last: 1'b1};
    end
  end

  // Pack the result beat.
  assign m_axis_tvalid = obuf_v;
  assign m_axis_tdata  = {3'b000, obuf.fin, obuf.pin, obuf.slot, obuf.accepted};
  assign m_axis_tuser  = obuf.kind;
  assign m_axis_tlast  = obuf.last;

endmodule

`default_nettype wire

// ----- rtl/mctbg_cell.sv -----
// One toggle channel: holds its task state and passes the scan token onward.
// Depends on mctbg_pkg for the control and report structures.
`default_nettype none

module mctbg_cell
  import mctbg_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire        clk,
  input  wire        rst,
  input  cell_ctl_t  ctl,
  input  wire        tok_in,
  output logic       tok,
  output cell_out_t  rpt
);

  logic              active;
  logic [PIN_W-1:0]  pin;
  logic [TGL_W-1:0]  left;
  logic [TIME_W-1:0] half;
  logic [TIME_W-1:0] due;
  logic [TIME_W-1:0] start_time;

  logic              fire;
  logic              claim;
  logic [TGL_W-1:0]  left_next;
  logic              fin;

  // Decide what this cell does while it holds the token.
  always_comb begin
    fire      = tok && !ctl.post && ctl.room && active &&
                reached(ctl.now, start_time) && reached(ctl.now, due);
    claim     = tok && ctl.post && !ctl.claimed && !active && (ctl.count != '0);
    left_next = (left != '0) ? left - TGL_W'(1) : '0;
    fin       = (left_next == '0);

    rpt       = '0;
    rpt.hit   = fire;
    rpt.claim = claim;
    rpt.slot  = SLOT_W'(IDX);
    rpt.pin   = tok ? pin : '0;
    rpt.fin   = fire && fin;
    if (!tok) begin
      rpt.slot = '0;
    end
  end

  // Token moves one cell along on every advancing cycle of a scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.start) begin
      tok <= (IDX == 0);
    end else if (ctl.advance) begin
      tok <= tok_in;
    end
  end

  // Channel occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.advance && claim) begin
      active <= 1'b1;
    end else if (ctl.advance && fire && fin) begin
      active <= 1'b0;
    end
  end

  // Task fields: loaded by a post, stepped by each toggle.
  always_ff @(posedge clk) begin
    if (ctl.advance && claim) begin
      pin        <= ctl.pin;
      left       <= ctl.count;
      half       <= ctl.half;
      due        <= ctl.start_time;
      start_time <= ctl.start_time;
    end else if (ctl.advance && fire) begin
      left <= left_next;
      if (!fin) begin
        due <= due + half;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mctbg_checker.sv -----
// Port-level checks on the result stream of the toggle burst generator.
// Depends on mctbg_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module mctbg_checker
  import mctbg_pkg::*;
(
  input wire                  clk,
  input wire                  rst,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [OUT_DATA_W-1:0] m_axis_tdata,
  input wire                  m_axis_tuser,
  input wire                  m_axis_tlast
);

  logic is_reply;
  logic is_toggle;

  assign is_reply  = m_axis_tvalid && (m_axis_tuser == KIND_REPLY);
  assign is_toggle = m_axis_tvalid && (m_axis_tuser == KIND_TOGGLE);

  // A reply beat always carries tlast, as a post answers with exactly one beat.
  `CHK_IMPLIES(a_reply_last, clk, rst, is_reply, m_axis_tlast, "reply beat without tlast")

  // A refused post names no channel.
  `CHK_IMPLIES(a_refused_slot, clk, rst, is_reply && !m_axis_tdata[0], m_axis_tdata[3:1] == 3'd0, "refused reply with nonzero slot")

  // Replies carry no pin and no finished flag.
  `CHK_IMPLIES(a_reply_clean, clk, rst, is_reply, m_axis_tdata[12:4] == 9'd0, "reply beat with pin or finished set")

  // Toggle events never claim acceptance.
  `CHK_IMPLIES(a_toggle_acc, clk, rst, is_toggle, !m_axis_tdata[0], "toggle beat with accepted set")

  // A stalled beat stays offered unchanged.
  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result beat changed")

endmodule

bind multi_channel_toggle_burst_generator_unit mctbg_checker u_mctbg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
